### hw/rtl/urh_pkg.sv
`default_nettype none

package urh_pkg;

  // field widths
  localparam int HANDLE_W   = 16;
  localparam int SIZE_W     = 24;
  localparam int REC_W      = SIZE_W + 1;
  localparam int BYTE_W     = 32;
  localparam int LIMIT_W    = 7;
  localparam int EVICT_W    = 7;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 7'd64;
  localparam logic [BYTE_W-1:0]  BUDGET_RESET = 32'd67108864;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET = 4'd1;

  // request actions
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_UNDO  = 2'd1,
    ACT_REDO  = 2'd2,
    ACT_CLEAR = 2'd3
  } urh_action_t;

  // shared adder operations
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } urh_alu_op_t;

  typedef struct packed {
    urh_alu_op_t       op;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] cmp;
  } urh_alu_req_t;

  // one history record as held in the store
  typedef struct packed {
    logic [HANDLE_W-1:0] before_ref;
    logic [HANDLE_W-1:0] after_ref;
    logic [HANDLE_W-1:0] sel_before_ref;
    logic [HANDLE_W-1:0] sel_after_ref;
    logic [REC_W-1:0]    rec_bytes;
    logic [HANDLE_W-1:0] label_id;
  } urh_entry_t;

endpackage

`default_nettype wire

### hw/rtl/urh_ifs.sv
`default_nettype none

// edit request channel
interface urh_req_if import urh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [HANDLE_W-1:0] before_ref;
  logic [HANDLE_W-1:0] after_ref;
  logic [SIZE_W-1:0]   before_bytes;
  logic [SIZE_W-1:0]   after_bytes;
  logic [HANDLE_W-1:0] label_id;
  logic [HANDLE_W-1:0] sel_before_ref;
  logic [HANDLE_W-1:0] sel_after_ref;
  logic                scene_valid;

  modport source (
    output valid, action, before_ref, after_ref, before_bytes, after_bytes,
           label_id, sel_before_ref, sel_after_ref, scene_valid,
    input  ready
  );
  modport sink (
    input  valid, action, before_ref, after_ref, before_bytes, after_bytes,
           label_id, sel_before_ref, sel_after_ref, scene_valid,
    output ready
  );
endinterface

// result channel
interface urh_rsp_if import urh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [HANDLE_W-1:0] snapshot_ref;
  logic [HANDLE_W-1:0] selection_ref;
  logic                can_undo;
  logic                can_redo;
  logic [HANDLE_W-1:0] undo_label;
  logic [HANDLE_W-1:0] redo_label;
  logic [EVICT_W-1:0]  evicted;

  modport source (
    output valid, ok, snapshot_ref, selection_ref, can_undo, can_redo,
           undo_label, redo_label, evicted,
    input  ready
  );
  modport sink (
    input  valid, ok, snapshot_ref, selection_ref, can_undo, can_redo,
           undo_label, redo_label, evicted,
    output ready
  );
endinterface

// configuration write channel
interface urh_cfg_if import urh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/urh_alu.sv
`default_nettype none

module urh_alu import urh_pkg::*; (
  input  urh_alu_req_t      req,
  output logic [BYTE_W-1:0] sum,
  output logic              gt
);

  // byte total add or subtract, then budget compare
  always_comb begin
    case (req.op)
      ALU_ADD: sum = req.a + req.b;
      ALU_SUB: sum = req.a - req.b;
      default: sum = req.a + req.b;
    endcase
    gt = (sum > req.cmp);
  end

endmodule

`default_nettype wire

### hw/rtl/urh_store.sv
`default_nettype none

module urh_store import urh_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  urh_entry_t        wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output urh_entry_t        rd_data
);

  urh_entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bounded_undo_redo_history_top.sv
// channel | dir | handshake   | payload
// req     | in  | valid/ready | action, before/after refs and bytes, label, sel refs, scene
// rsp     | out | valid/ready | ok, snapshot/selection refs, can_undo/redo, labels, evicted
// cfg     | in  | valid/ready | index (0 entry_limit, 1 byte_budget), data; always ready
//
// sequencing: one request at a time; a clear or failed undo/redo runs only the label
// steps, undo/redo first moves the cursor, push trims, retires the oldest record when
// the store is full, appends, then evicts; the single store read port and the shared
// adder set this.
// reset: synchronous, empties the history, limits back to 64 records / 64 MiB.
// stalls: a finished result waits in the output register while the next request
// is taken; the sequencer holds on its last step only if that register is full.
`default_nettype none

module bounded_undo_redo_history_top import urh_pkg::*; #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  urh_req_if.sink     req,
  urh_rsp_if.source   rsp,
  urh_cfg_if.sink     cfg
);

  localparam int IW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int EW = CW + 1;
  localparam int SW = CW + 1;
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_TRIM      = 12'b0000_0000_0010,
    S_FULL_SUB  = 12'b0000_0000_0100,
    S_WRITE     = 12'b0000_0000_1000,
    S_EVICT_CHK = 12'b0000_0001_0000,
    S_EVICT_SUB = 12'b0000_0010_0000,
    S_MOVE_RD   = 12'b0000_0100_0000,
    S_MOVE_SUB  = 12'b0000_1000_0000,
    S_MOVE_ADD  = 12'b0001_0000_0000,
    S_LBL_A     = 12'b0010_0000_0000,
    S_LBL_B     = 12'b0100_0000_0000,
    S_LBL_C     = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // history control
  logic [IW-1:0]      oldest;
  logic [CW-1:0]      count;
  logic [CW-1:0]      cursor;
  logic [BYTE_W-1:0]  below;
  logic [BYTE_W-1:0]  above;
  logic [LIMIT_W-1:0] entry_limit;
  logic [BYTE_W-1:0]  byte_budget;

  // request in progress
  logic                mv_undo;
  logic [HANDLE_W-1:0] p_before_ref;
  logic [HANDLE_W-1:0] p_after_ref;
  logic [SIZE_W-1:0]   p_before_bytes;
  logic [SIZE_W-1:0]   p_after_bytes;
  logic [HANDLE_W-1:0] p_label_id;
  logic [HANDLE_W-1:0] p_sel_before_ref;
  logic [HANDLE_W-1:0] p_sel_after_ref;
  logic [REC_W-1:0]    rb_new;
  logic [EW-1:0]       evicted;
  logic                res_ok;
  logic [HANDLE_W-1:0] res_snap;
  logic [HANDLE_W-1:0] res_sel;
  logic [HANDLE_W-1:0] lbl_undo;

  // output register
  logic                rsp_valid;
  logic                out_ok;
  logic [HANDLE_W-1:0] out_snap;
  logic [HANDLE_W-1:0] out_sel;
  logic                out_can_undo;
  logic                out_can_redo;
  logic [HANDLE_W-1:0] out_undo_label;
  logic [HANDLE_W-1:0] out_redo_label;
  logic [EVICT_W-1:0]  out_evicted;

  // store ports and shared adder
  logic         st_wr_en;
  logic         st_rd_en;
  logic [IW-1:0] slot;
  urh_entry_t   st_wr_data;
  urh_entry_t   st_rd_data;
  urh_alu_req_t alu_req;
  logic [BYTE_W-1:0] alu_sum;
  logic         alu_gt;

  logic [CW-1:0] pos;
  logic [SW-1:0] slot_sum;
  logic [SW-1:0] slot_wrap;
  logic [IW-1:0] oldest_inc;
  logic          cursor_nz;
  logic          has_redo;
  logic          is_full;
  logic          evict_need;
  logic          rsp_free;
  urh_action_t   req_action;

  assign req_action = urh_action_t'(req.action);
  assign cursor_nz  = (cursor != '0);
  assign has_redo   = (cursor < count);
  assign is_full    = (cursor == CW'(HISTORY_DEPTH));
  assign rsp_free   = !rsp_valid || rsp.ready;
  assign oldest_inc = (oldest == IW'(HISTORY_DEPTH - 1)) ? '0 : oldest + IW'(1);

  // record position relative to the oldest record, per step
  always_comb begin
    case (state)
      S_WRITE:   pos = count;
      S_MOVE_RD: pos = mv_undo ? cursor - CW'(1) : cursor;
      S_LBL_A:   pos = cursor - CW'(1);
      S_LBL_B:   pos = cursor;
      default:   pos = '0;
    endcase
  end

  // ring slot of that position
  assign slot_sum  = SW'(oldest) + SW'(pos);
  assign slot_wrap = slot_sum - SW'(HISTORY_DEPTH);
  assign slot      = (slot_sum >= SW'(HISTORY_DEPTH)) ? slot_wrap[IW-1:0] : slot_sum[IW-1:0];

  // operand selection for the shared adder
  always_comb begin
    alu_req.op  = ALU_ADD;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.cmp = byte_budget;
    case (state)
      S_TRIM: begin
        alu_req.a = BYTE_W'(p_before_bytes);
        alu_req.b = BYTE_W'(p_after_bytes);
      end
      S_FULL_SUB: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = below;
        alu_req.b  = BYTE_W'(st_rd_data.rec_bytes);
      end
      S_WRITE: begin
        alu_req.a = below;
        alu_req.b = BYTE_W'(rb_new);
      end
      S_EVICT_CHK: begin
        alu_req.a = below;
        alu_req.b = above;
      end
      S_EVICT_SUB: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = cursor_nz ? below : above;
        alu_req.b  = BYTE_W'(st_rd_data.rec_bytes);
      end
      S_MOVE_SUB: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = mv_undo ? below : above;
        alu_req.b  = BYTE_W'(st_rd_data.rec_bytes);
      end
      S_MOVE_ADD: begin
        alu_req.a = mv_undo ? above : below;
        alu_req.b = BYTE_W'(st_rd_data.rec_bytes);
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  urh_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .gt  (alu_gt)
  );

  // eviction test: over the entry limit, or over budget with more than one left
  assign evict_need = (LW'(count) > LW'(entry_limit)) || (alu_gt && (count > CW'(1)));

  // store read and write enables
  always_comb begin
    st_wr_en = (state == S_WRITE);
    case (state)
      S_TRIM:      st_rd_en = is_full;
      S_EVICT_CHK: st_rd_en = evict_need;
      S_MOVE_RD:   st_rd_en = 1'b1;
      S_LBL_A:     st_rd_en = cursor_nz;
      S_LBL_B:     st_rd_en = has_redo;
      default:     st_rd_en = 1'b0;
    endcase
  end

  assign st_wr_data.before_ref     = p_before_ref;
  assign st_wr_data.after_ref      = p_after_ref;
  assign st_wr_data.sel_before_ref = p_sel_before_ref;
  assign st_wr_data.sel_after_ref  = p_sel_after_ref;
  assign st_wr_data.rec_bytes      = rb_new;
  assign st_wr_data.label_id       = p_label_id;

  urh_store #(
    .DEPTH (HISTORY_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (slot),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (slot),
    .rd_data (st_rd_data)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // output register valid: raised on the last step, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_LBL_C) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      oldest      <= '0;
      count       <= '0;
      cursor      <= '0;
      below       <= '0;
      above       <= '0;
      entry_limit <= LIMIT_RESET;
      byte_budget <= BUDGET_RESET;
    end else begin
      // configuration writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_ENTRY_LIMIT: entry_limit <= cfg.data[LIMIT_W-1:0];
          CFG_BYTE_BUDGET: byte_budget <= cfg.data[BYTE_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            p_before_ref     <= req.before_ref;
            p_after_ref      <= req.after_ref;
            p_before_bytes   <= req.before_bytes;
            p_after_bytes    <= req.after_bytes;
            p_label_id       <= req.label_id;
            p_sel_before_ref <= req.sel_before_ref;
            p_sel_after_ref  <= req.sel_after_ref;
            evicted          <= '0;
            res_snap         <= '0;
            res_sel          <= '0;
            case (req_action)
              ACT_PUSH: begin
                res_ok <= 1'b1;
                state  <= S_TRIM;
              end
              ACT_UNDO: begin
                mv_undo <= 1'b1;
                if (cursor_nz && req.scene_valid) begin
                  res_ok <= 1'b1;
                  state  <= S_MOVE_RD;
                end else begin
                  res_ok <= 1'b0;
                  state  <= S_LBL_A;
                end
              end
              ACT_REDO: begin
                mv_undo <= 1'b0;
                if (has_redo && req.scene_valid) begin
                  res_ok <= 1'b1;
                  state  <= S_MOVE_RD;
                end else begin
                  res_ok <= 1'b0;
                  state  <= S_LBL_A;
                end
              end
              ACT_CLEAR: begin
                oldest <= '0;
                count  <= '0;
                cursor <= '0;
                below  <= '0;
                above  <= '0;
                res_ok <= 1'b1;
                state  <= S_LBL_A;
              end
              default: begin
                res_ok <= 1'b0;
                state  <= S_LBL_A;
              end
            endcase
          end
        end

        // drop redo records, size the new record
        S_TRIM: begin
          count  <= cursor;
          above  <= '0;
          rb_new <= alu_sum[REC_W-1:0];
          state  <= is_full ? S_FULL_SUB : S_WRITE;
        end

        // full store: oldest record goes before the append
        S_FULL_SUB: begin
          below   <= alu_sum;
          cursor  <= cursor - CW'(1);
          count   <= count - CW'(1);
          oldest  <= oldest_inc;
          evicted <= evicted + EW'(1);
          state   <= S_WRITE;
        end

        // append the new record
        S_WRITE: begin
          count  <= count + CW'(1);
          cursor <= count + CW'(1);
          below  <= alu_sum;
          state  <= S_EVICT_CHK;
        end

        S_EVICT_CHK: begin
          state <= evict_need ? S_EVICT_SUB : S_LBL_A;
        end

        // retire the oldest record
        S_EVICT_SUB: begin
          if (cursor_nz) begin
            below  <= alu_sum;
            cursor <= cursor - CW'(1);
          end else begin
            above <= alu_sum;
          end
          oldest  <= oldest_inc;
          count   <= count - CW'(1);
          evicted <= evicted + EW'(1);
          state   <= S_EVICT_CHK;
        end

        // undo or redo: move the cursor and one record's bytes
        S_MOVE_RD: begin
          cursor <= mv_undo ? cursor - CW'(1) : cursor + CW'(1);
          state  <= S_MOVE_SUB;
        end

        S_MOVE_SUB: begin
          res_snap <= mv_undo ? st_rd_data.before_ref : st_rd_data.after_ref;
          res_sel  <= mv_undo ? st_rd_data.sel_before_ref : st_rd_data.sel_after_ref;
          if (mv_undo) begin
            below <= alu_sum;
          end else begin
            above <= alu_sum;
          end
          state <= S_MOVE_ADD;
        end

        S_MOVE_ADD: begin
          if (mv_undo) begin
            above <= alu_sum;
          end else begin
            below <= alu_sum;
          end
          state <= S_LBL_A;
        end

        // peek labels around the cursor
        S_LBL_A: begin
          state <= S_LBL_B;
        end

        S_LBL_B: begin
          lbl_undo <= cursor_nz ? st_rd_data.label_id : '0;
          state    <= S_LBL_C;
        end

        S_LBL_C: begin
          if (rsp_free) begin
            out_ok         <= res_ok;
            out_snap       <= res_snap;
            out_sel        <= res_sel;
            out_can_undo   <= cursor_nz;
            out_can_redo   <= has_redo;
            out_undo_label <= lbl_undo;
            out_redo_label <= has_redo ? st_rd_data.label_id : '0;
            out_evicted    <= EVICT_W'(evicted);
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // result port
  assign rsp.valid         = rsp_valid;
  assign rsp.ok            = out_ok;
  assign rsp.snapshot_ref  = out_snap;
  assign rsp.selection_ref = out_sel;
  assign rsp.can_undo      = out_can_undo;
  assign rsp.can_redo      = out_can_redo;
  assign rsp.undo_label    = out_undo_label;
  assign rsp.redo_label    = out_redo_label;
  assign rsp.evicted       = out_evicted;

  // cursor never passes the newest record
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("cursor above record count");

  // record count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HISTORY_DEPTH))
    else $error("record count above store depth");

  // a clear leaves an empty history
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.action == ACT_CLEAR)) |=>
      (count == '0 && cursor == '0 && oldest == '0))
    else $error("clear did not empty history");

  // a result appears only from the last sequencer step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_LBL_C))
    else $error("result raised outside final step");

endmodule

`default_nettype wire
